// ===== rtl/thv_pkg.sv =====
// Package with shared types and constants for the thresholded volume histogram.
`timescale 1ns / 1ps
package thv_pkg;

  localparam int BIN_COUNT = 256;
  localparam int BIN_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W = 12;
  localparam int THRESH_W = 13;
  localparam int OUT_COUNT_W = 32;
  localparam int BIN_SHIFT_12 = 4;
  localparam logic [VALUE_W-1:0] SAMPLE_MAX_12 = 12'hFFF;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_DATA_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_READ = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_all;
    logic add_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/thv_in_if.sv =====
// Input item channel with valid/ready handshake.
`timescale 1ns / 1ps
interface thv_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic [thv_pkg::SAMPLE_W-1:0]      sample_value;
  logic [thv_pkg::BIN_W-1:0]         bin_select;

  modport source (output valid, output op, output sample_value, output bin_select,
                  input ready);
  modport sink (input valid, input op, input sample_value, input bin_select,
                output ready);
endinterface

// ===== rtl/thv_out_if.sv =====
// Result item channel with valid/ready handshake.
`timescale 1ns / 1ps
interface thv_out_if;
  logic                              valid;
  logic                              ready;
  logic [thv_pkg::OUT_COUNT_W-1:0]   bin_count;
  logic [thv_pkg::BIN_W-1:0]         bin_echo;

  modport source (output valid, output bin_count, output bin_echo, input ready);
  modport sink (input valid, input bin_count, input bin_echo, output ready);
endinterface

// ===== rtl/thv_ctrl.sv =====
// Controller state machine sequencing clear, add and read items.
`timescale 1ns / 1ps
module thv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  thv_pkg::status_t status,
  output thv_pkg::cmd_t    cmd
);

  thv_pkg::state_t state_r;
  thv_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= thv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      thv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (status.op)
            thv_pkg::OP_CLEAR: cmd.clear_all = 1'b1;
            thv_pkg::OP_ADD:   state_nxt = thv_pkg::ST_ADD;
            thv_pkg::OP_READ:  state_nxt = thv_pkg::ST_READ;
            default:           state_nxt = thv_pkg::ST_IDLE;
          endcase
        end
      end
      thv_pkg::ST_ADD: begin
        cmd.add_commit = 1'b1;
        state_nxt      = thv_pkg::ST_IDLE;
      end
      thv_pkg::ST_READ: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = thv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = thv_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/thv_datapath.sv =====
// Datapath: config registers, bin memory with valid bits, increment and result register.
`timescale 1ns / 1ps
module thv_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [thv_pkg::THRESH_W-1:0]     cfg_wdata,
  input  logic [1:0]                       in_op,
  input  logic [thv_pkg::SAMPLE_W-1:0]     in_sample_value,
  input  logic [thv_pkg::BIN_W-1:0]        in_bin_select,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [thv_pkg::OUT_COUNT_W-1:0]  out_bin_count,
  output logic [thv_pkg::BIN_W-1:0]        out_bin_echo,
  input  thv_pkg::cmd_t                    cmd,
  output thv_pkg::status_t                 status
);

  localparam int WIDE_W = (COUNT_WIDTH > thv_pkg::OUT_COUNT_W) ?
                          COUNT_WIDTH : thv_pkg::OUT_COUNT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [WIDE_W-1:0] OUT_MAX = WIDE_W'({thv_pkg::OUT_COUNT_W{1'b1}});

  logic [thv_pkg::THRESH_W-1:0]     thresh_r;
  logic                             mode_r;
  logic [COUNT_WIDTH-1:0]           mem [thv_pkg::BIN_COUNT];
  logic [COUNT_WIDTH-1:0]           rdata_r;
  logic [thv_pkg::BIN_COUNT-1:0]    valid_r;
  logic [thv_pkg::BIN_W-1:0]        bin_r;
  logic                             qual_r;
  logic                             out_valid_r;
  logic [thv_pkg::OUT_COUNT_W-1:0]  out_count_r;
  logic [thv_pkg::BIN_W-1:0]        out_echo_r;

  logic [thv_pkg::VALUE_W-1:0]      value;
  logic [thv_pkg::BIN_W-1:0]        sample_bin;
  logic [thv_pkg::BIN_W-1:0]        addr;
  logic                             qual;
  logic [COUNT_WIDTH-1:0]           cnt;
  logic                             do_write;
  logic [WIDE_W-1:0]                cnt_wide;
  logic [thv_pkg::OUT_COUNT_W-1:0]  cnt_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        thv_pkg::CFG_THRESHOLD: thresh_r <= cfg_wdata;
        thv_pkg::CFG_DATA_MODE: mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mode_r) begin
      if (in_sample_value > thv_pkg::SAMPLE_W'(thv_pkg::SAMPLE_MAX_12)) begin
        value = thv_pkg::SAMPLE_MAX_12;
      end else begin
        value = in_sample_value[thv_pkg::VALUE_W-1:0];
      end
      sample_bin = value[thv_pkg::BIN_SHIFT_12 +: thv_pkg::BIN_W];
    end else begin
      value      = thv_pkg::VALUE_W'(in_sample_value[thv_pkg::BIN_W-1:0]);
      sample_bin = in_sample_value[thv_pkg::BIN_W-1:0];
    end
    qual = thv_pkg::THRESH_W'(value) >= thresh_r;
    addr = (in_op == thv_pkg::OP_READ) ? in_bin_select : sample_bin;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin_r  <= addr;
      qual_r <= qual;
    end
  end

  always_comb begin
    cnt      = valid_r[bin_r] ? rdata_r : '0;
    do_write = cmd.add_commit && qual_r && (cnt != CNT_MAX);
    cnt_wide = WIDE_W'(cnt);
    cnt_out  = (cnt_wide > OUT_MAX) ? {thv_pkg::OUT_COUNT_W{1'b1}} :
                                      cnt_wide[thv_pkg::OUT_COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[bin_r] <= cnt + COUNT_WIDTH'(1);
    end
    if (cmd.capture) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[bin_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= cnt_out;
      out_echo_r  <= bin_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_count   = out_count_r;
  assign out_bin_echo    = out_echo_r;
  assign status.op       = in_op;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// ===== rtl/thresholded_volume_histogram.sv =====
// Clear resets the bin valid bits when taken; add captures bin, qualify flag and count,
// then writes the incremented count in ST_ADD; read captures bin and count, then loads
// the result in ST_READ and waits while it is held. Items are taken only when idle.
// Reset: synchronous active-low rst_n clears the bin valid bits at once (all bins read
// zero), the config registers and the controller; no clearing pass is needed.
`timescale 1ns / 1ps
module thresholded_volume_histogram #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [thv_pkg::THRESH_W-1:0]  cfg_wdata,
  thv_in_if.sink                        in_item,
  thv_out_if.source                     out_item
);

  thv_pkg::cmd_t    cmd;
  thv_pkg::status_t status;

  thv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  thv_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_item.op),
    .in_sample_value (in_item.sample_value),
    .in_bin_select   (in_item.bin_select),
    .out_ready       (out_item.ready),
    .out_valid       (out_item.valid),
    .out_bin_count   (out_item.bin_count),
    .out_bin_echo    (out_item.bin_echo),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
